>>> rtl/dfl_pkg.sv
package dfl_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int DW         = 16;
	localparam int DIMW       = 10;
	localparam int FRW        = 16;
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);
	localparam int AW         = 5;

	localparam logic [DW-1:0] FOUND_THRESHOLD = 16'd10;

	localparam logic [DW-1:0]   RST_DEPTH_LOW  = 16'd100;
	localparam logic [DW-1:0]   RST_DEPTH_HIGH = 16'd1300;
	localparam logic [DW-1:0]   RST_CONF_FLOOR = 16'd100;
	localparam logic [DIMW-1:0] RST_WIDTH      = 10'd320;
	localparam logic [DIMW-1:0] RST_HEIGHT     = 10'd240;

	typedef enum logic [2:0] {
		REG_DEPTH_LOW    = 3'd0,
		REG_DEPTH_HIGH   = 3'd1,
		REG_CONF_FLOOR   = 3'd2,
		REG_FRAME_WIDTH  = 3'd3,
		REG_FRAME_HEIGHT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DW-1:0] depth_low;
		logic [DW-1:0] depth_high;
		logic [DW-1:0] conf_floor;
		logic [XW-1:0] last_col;
		logic [YW-1:0] last_row;
	} cfg_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic          valid_px;
		logic [DW-1:0] depth;
		logic          row_end;
		logic          frame_end;
	} pix_t;

	typedef struct packed {
		logic [FRW-1:0] frame;
		logic [DW-1:0]  depth;
		logic [YW-1:0]  y;
		logic [XW-1:0]  x;
		logic           found;
	} res_t;

	// last index of a dimension after clamping it to 1..lim
	function automatic logic [DIMW-1:0] dim_last(input logic [DIMW-1:0] dim,
			input logic [DIMW:0] lim);
		logic [DIMW:0] t;
		if (dim == '0) begin
			t = '0;
		end else if ({1'b0, dim} > lim) begin
			t = lim - 1'b1;
		end else begin
			t = {1'b0, dim} - 1'b1;
		end
		return t[DIMW-1:0];
	endfunction

endpackage

>>> rtl/depth_fingertip_locator.sv
// Fingertip locator for a depth camera stream. Each s_tdata transaction is one
// pixel (depth, confidence) in raster order; the frame is framed purely by the
// frame_width/frame_height registers, and one m_tdata transaction with the
// nearest surviving point (after 3x3 erosion of the valid mask) comes out
// after the last pixel of each frame. The back end processes one pixel per
// clock while the queue holds data, but pauses after every row end for the
// erosion window flush and at frame end; a 4-entry queue buffers incoming
// pixels, so s_tready drops only when it fills. After the last pixel the
// bottom row is swept again from the line memories before the result. The line
// memories need no clearing after reset. Writing frame_width or frame_height
// restarts the frame; write registers only while no frame is in flight.
module depth_fingertip_locator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [31:0]            s_tdata,   // [15:0] depth_sample, [31:16] confidence_sample
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [55:0]            m_tdata,   // [0] tip_found, [9:1] tip_x, [18:10] tip_y,
	                                          // [34:19] tip_depth, [50:35] frame_number
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [dfl_pkg::AW-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [dfl_pkg::DW-1:0]   depth_low_q;
	logic [dfl_pkg::DW-1:0]   depth_high_q;
	logic [dfl_pkg::DW-1:0]   conf_floor_q;
	logic [dfl_pkg::DIMW-1:0] width_q;
	logic [dfl_pkg::DIMW-1:0] height_q;

	dfl_pkg::reg_idx_t idx;
	logic              wr;
	logic              frame_clr;
	dfl_pkg::cfg_t     cfg;
	logic [dfl_pkg::DIMW-1:0] lc;
	logic [dfl_pkg::DIMW-1:0] lr;

	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	dfl_pkg::pix_t push_data;
	dfl_pkg::pix_t pop_data;

	logic          res_valid;
	logic          res_ready;
	dfl_pkg::res_t res;

	logic          m_tvalid_q;
	dfl_pkg::res_t m_res_q;

	assign pready    = 1'b1;
	assign idx       = dfl_pkg::reg_idx_t'(paddr[dfl_pkg::AW-1:2]);
	assign wr        = psel && penable && pwrite && pready;
	assign frame_clr = wr && ((idx == dfl_pkg::REG_FRAME_WIDTH) ||
		(idx == dfl_pkg::REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_low_q  <= dfl_pkg::RST_DEPTH_LOW;
			depth_high_q <= dfl_pkg::RST_DEPTH_HIGH;
			conf_floor_q <= dfl_pkg::RST_CONF_FLOOR;
			width_q      <= dfl_pkg::RST_WIDTH;
			height_q     <= dfl_pkg::RST_HEIGHT;
		end else if (wr) begin
			case (idx)
				dfl_pkg::REG_DEPTH_LOW:    depth_low_q  <= pwdata[dfl_pkg::DW-1:0];
				dfl_pkg::REG_DEPTH_HIGH:   depth_high_q <= pwdata[dfl_pkg::DW-1:0];
				dfl_pkg::REG_CONF_FLOOR:   conf_floor_q <= pwdata[dfl_pkg::DW-1:0];
				dfl_pkg::REG_FRAME_WIDTH:  width_q      <= pwdata[dfl_pkg::DIMW-1:0];
				dfl_pkg::REG_FRAME_HEIGHT: height_q     <= pwdata[dfl_pkg::DIMW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			dfl_pkg::REG_DEPTH_LOW:    prdata = {16'd0, depth_low_q};
			dfl_pkg::REG_DEPTH_HIGH:   prdata = {16'd0, depth_high_q};
			dfl_pkg::REG_CONF_FLOOR:   prdata = {16'd0, conf_floor_q};
			dfl_pkg::REG_FRAME_WIDTH:  prdata = {22'd0, width_q};
			dfl_pkg::REG_FRAME_HEIGHT: prdata = {22'd0, height_q};
			default:                   prdata = '0;
		endcase
	end

	assign lc = dfl_pkg::dim_last(width_q, (dfl_pkg::DIMW+1)'(dfl_pkg::MAX_WIDTH));
	assign lr = dfl_pkg::dim_last(height_q, (dfl_pkg::DIMW+1)'(dfl_pkg::MAX_HEIGHT));

	always_comb begin
		cfg.depth_low  = depth_low_q;
		cfg.depth_high = depth_high_q;
		cfg.conf_floor = conf_floor_q;
		cfg.last_col   = lc[dfl_pkg::XW-1:0];
		cfg.last_row   = lr[dfl_pkg::YW-1:0];
	end

	dfl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.frame_clr (frame_clr),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	dfl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	dfl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.frame_clr (frame_clr),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, m_res_q};

endmodule

>>> rtl/dfl_front.sv
module dfl_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dfl_pkg::cfg_t         cfg,
	input  logic                  frame_clr,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic                  q_full,
	output logic                  push,
	output dfl_pkg::pix_t         push_data
);

	logic [dfl_pkg::XW-1:0] x_q;
	logic [dfl_pkg::YW-1:0] y_q;
	logic [dfl_pkg::DW-1:0] depth;
	logic [dfl_pkg::DW-1:0] conf;
	logic                   row_end;
	logic                   frame_end;

	assign s_tready  = !q_full;
	assign push      = s_tvalid && s_tready;
	assign depth     = s_tdata[15:0];
	assign conf      = s_tdata[31:16];
	assign row_end   = (x_q == cfg.last_col);
	assign frame_end = row_end && (y_q == cfg.last_row);

	always_comb begin
		push_data.x         = x_q;
		push_data.y         = y_q;
		push_data.valid_px  = (depth >= cfg.depth_low) && (depth <= cfg.depth_high) &&
			(conf > cfg.conf_floor);
		push_data.depth     = depth;
		push_data.row_end   = row_end;
		push_data.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (frame_clr) begin
			x_q <= '0;
			y_q <= '0;
		end else if (push) begin
			if (row_end) begin
				x_q <= '0;
				y_q <= frame_end ? '0 : y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/dfl_queue.sv
module dfl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dfl_pkg::pix_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output dfl_pkg::pix_t pop_data
);

	dfl_pkg::pix_t           mem_q [dfl_pkg::QDEPTH];
	logic [dfl_pkg::QAW-1:0] wr_ptr_q;
	logic [dfl_pkg::QAW-1:0] rd_ptr_q;
	logic [dfl_pkg::QAW:0]   count_q;

	assign full     = (count_q == (dfl_pkg::QAW+1)'(dfl_pkg::QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/dfl_back.sv
module dfl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  dfl_pkg::cfg_t cfg,
	input  logic          frame_clr,
	input  logic          q_empty,
	input  dfl_pkg::pix_t q_data,
	output logic          q_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output dfl_pkg::res_t res
);

	typedef enum logic [3:0] {
		ST_RUN   = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} bst_t;

	bst_t state_q;

	// line stores: per column {mask of row y-1, mask of row y-2} and depth of row y-1
	logic [1:0]             mask_mem [dfl_pkg::MAX_WIDTH];
	logic [dfl_pkg::DW-1:0] dep_mem  [dfl_pkg::MAX_WIDTH];

	logic [dfl_pkg::XW-1:0] sc_q;
	logic                   issue_px;
	logic                   issue_sw;
	logic                   blk;
	logic [dfl_pkg::XW-1:0] rd_addr;

	logic                   vld_s1;
	logic                   sweep_s1;
	logic [dfl_pkg::XW-1:0] x_s1;
	logic [dfl_pkg::YW-1:0] y_s1;
	logic                   mask_s1;
	logic [dfl_pkg::DW-1:0] depth_s1;
	logic                   rowend_s1;
	logic [1:0]             rd_m_s1;
	logic [dfl_pkg::DW-1:0] rd_d_s1;

	logic                   feed;
	logic [2:0]             col;
	logic [dfl_pkg::YW-1:0] crow;
	logic                   top_ok;

	logic                   flush_q;
	logic [dfl_pkg::YW-1:0] frow_q;
	logic [2:0]             win_l_q;
	logic [2:0]             win_m_q;
	logic [2:0]             win_r_q;
	logic [dfl_pkg::DW-1:0] dep_m_q;
	logic [dfl_pkg::DW-1:0] dep_r_q;
	logic                   ev_q;
	logic [dfl_pkg::XW-1:0] ev_x_q;
	logic [dfl_pkg::YW-1:0] ev_y_q;

	logic                   survive;
	logic [dfl_pkg::DW-1:0] score;
	logic                   upd;

	logic [dfl_pkg::DW-1:0]  best_score_q;
	logic [dfl_pkg::XW-1:0]  best_x_q;
	logic [dfl_pkg::YW-1:0]  best_y_q;
	logic [dfl_pkg::DW-1:0]  best_dep_q;
	logic [dfl_pkg::FRW-1:0] frames_q;

	// a row end needs the next cycle for the window flush; also keeps a
	// single-column frame from reading a column in the cycle it is written
	assign blk      = vld_s1 && rowend_s1;
	assign issue_px = (state_q == ST_RUN) && !q_empty && !blk;
	assign issue_sw = (state_q == ST_SWEEP) && !blk;
	assign q_pop    = issue_px;
	assign rd_addr  = issue_px ? q_data.x : sc_q;

	always_ff @(posedge clk) begin
		if (issue_px || issue_sw) begin
			rd_m_s1 <= mask_mem[rd_addr];
			rd_d_s1 <= dep_mem[rd_addr];
		end
		if (vld_s1 && !sweep_s1) begin
			mask_mem[x_s1] <= {mask_s1, rd_m_s1[1]};
			dep_mem[x_s1]  <= depth_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_px) begin
			sweep_s1  <= 1'b0;
			x_s1      <= q_data.x;
			y_s1      <= q_data.y;
			mask_s1   <= q_data.valid_px;
			depth_s1  <= q_data.depth;
			rowend_s1 <= q_data.row_end;
		end else if (issue_sw) begin
			sweep_s1  <= 1'b1;
			x_s1      <= sc_q;
			y_s1      <= cfg.last_row;
			mask_s1   <= 1'b1;
			depth_s1  <= '0;
			rowend_s1 <= (sc_q == cfg.last_col);
		end
	end

	// pixel row y feeds the centers of row y-1; the sweep feeds the bottom row
	assign feed   = vld_s1 && (sweep_s1 || (y_s1 != '0));
	assign top_ok = sweep_s1 ? (cfg.last_row != '0) : (y_s1[dfl_pkg::YW-1:1] != '0);
	assign col    = {mask_s1, rd_m_s1[1], top_ok ? rd_m_s1[0] : 1'b1};
	assign crow   = sweep_s1 ? cfg.last_row : y_s1 - 1'b1;

	always_ff @(posedge clk) begin
		if (flush_q) begin
			win_l_q <= win_m_q;
			win_m_q <= win_r_q;
			win_r_q <= 3'b111;
			dep_m_q <= dep_r_q;
			ev_x_q  <= cfg.last_col;
			ev_y_q  <= frow_q;
		end else if (feed) begin
			if (x_s1 == '0) begin
				win_l_q <= 3'b111;
				win_m_q <= 3'b111;
			end else begin
				win_l_q <= win_m_q;
				win_m_q <= win_r_q;
				dep_m_q <= dep_r_q;
			end
			win_r_q <= col;
			dep_r_q <= rd_d_s1;
			ev_x_q  <= x_s1 - 1'b1;
			ev_y_q  <= crow;
		end
		if (vld_s1) begin
			frow_q <= crow;
		end
	end

	assign survive = &{win_l_q, win_m_q, win_r_q};
	assign score   = (dep_m_q <= cfg.depth_high) ? cfg.depth_high - dep_m_q : '0;
	assign upd     = ev_q && survive && (score > best_score_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			sc_q         <= '0;
			vld_s1       <= 1'b0;
			flush_q      <= 1'b0;
			ev_q         <= 1'b0;
			best_score_q <= '0;
			best_x_q     <= '0;
			best_y_q     <= '0;
			best_dep_q   <= '0;
			frames_q     <= '0;
		end else begin
			vld_s1  <= issue_px || issue_sw;
			flush_q <= blk && feed;
			ev_q    <= flush_q || (feed && (x_s1 != '0));

			case (state_q)
				ST_RUN: begin
					if (issue_px && q_data.frame_end) begin
						state_q <= ST_SWEEP;
						sc_q    <= '0;
					end
				end
				ST_SWEEP: begin
					if (issue_sw) begin
						sc_q <= sc_q + 1'b1;
						if (sc_q == cfg.last_col) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !flush_q && !ev_q) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase

			if (frame_clr || ((state_q == ST_EMIT) && res_ready)) begin
				best_score_q <= '0;
				best_x_q     <= '0;
				best_y_q     <= '0;
				best_dep_q   <= '0;
			end else if (upd) begin
				best_score_q <= score;
				best_x_q     <= ev_x_q;
				best_y_q     <= ev_y_q;
				best_dep_q   <= dep_m_q;
			end
			if ((state_q == ST_EMIT) && res_ready) begin
				frames_q <= frames_q + 1'b1;
			end
		end
	end

	assign res_valid = (state_q == ST_EMIT);

	always_comb begin
		res.found = (best_score_q > dfl_pkg::FOUND_THRESHOLD);
		res.x     = best_x_q;
		res.y     = best_y_q;
		res.depth = best_dep_q;
		res.frame = frames_q;
	end

endmodule

>>> rtl/dfl_checker.sv
module dfl_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [31:0]            s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [55:0]            m_tdata,
	input logic                   psel,
	input logic                   penable,
	input logic                   pwrite,
	input logic [dfl_pkg::AW-1:0] paddr,
	input logic [31:0]            pwdata,
	input logic [31:0]            prdata,
	input logic                   pready
);

	logic [15:0] frame_cnt_q;
	logic [15:0] low_shadow_q;
	logic        low_sel;

	assign low_sel = (paddr[dfl_pkg::AW-1:2] == dfl_pkg::REG_DEPTH_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q  <= '0;
			low_shadow_q <= dfl_pkg::RST_DEPTH_LOW;
		end else begin
			if (m_tvalid && m_tready) begin
				frame_cnt_q <= frame_cnt_q + 1'b1;
			end
			if (psel && penable && pwrite && pready && low_sel) begin
				low_shadow_q <= pwdata[15:0];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_frame_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[50:35] == frame_cnt_q))
		else $error("frame number out of sequence");

	a_low_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && low_sel |-> (prdata == {16'd0, low_shadow_q}))
		else $error("depth_low readback mismatch");

	a_found_depth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[34:19] < 16'd65525))
		else $error("found tip with impossible depth");

endmodule

bind depth_fingertip_locator dfl_checker u_dfl_checker (.*);
